// ===== rtl/sslc_pkg.sv =====
// Types, codes and defaults shared by the segment summary LRU cache.
package sslc_pkg;

  localparam int unsigned BUCKETS_DEF   = 64;
  localparam int unsigned WAYS_DEF      = 4;
  localparam int unsigned CUR_SLOTS_DEF = 3;

  localparam int unsigned KEY_W      = 32;
  localparam int unsigned HANDLE_W   = 16;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned SLOT_W     = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned FOOTER_W   = 6;
  localparam int unsigned FOOTER_DATA_BASE = 3;

  localparam logic [KEY_W-1:0]    CUR_SEG_RST = '1;
  localparam logic [FOOTER_W-1:0] FOOTER_RST  = 6'd7;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NODE_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NODE_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NODE_C = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_A = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_B = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_C = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FOOTER = 3'd6;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_MISS     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SLOT_OK  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SLOT_BAD = 3'd2;
  localparam logic [KIND_W-1:0] KIND_HIT      = 3'd3;
  localparam logic [KIND_W-1:0] KIND_INSERT   = 3'd4;

  localparam logic ACT_INSERT = 1'b1;
  localparam logic TBL_NODE   = 1'b1;

  typedef struct packed {
    logic                action;
    logic                table_req;
    logic [KEY_W-1:0]    segment;
    logic [HANDLE_W-1:0] handle;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [SLOT_W-1:0]   current_slot;
    logic [HANDLE_W-1:0] found_handle;
    logic                evicted_valid;
    logic [HANDLE_W-1:0] evicted_handle;
  } out_item_t;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

endpackage

// ===== rtl/segment_summary_lru_cache_core.sv =====
// Segment summary LRU cache: two set-associative tables in block memories.
//
//   channel | ports                          | beat taken when
//   --------+--------------------------------+------------------------------
//   input   | start, busy, in_data           | start high and busy low
//   result  | out_valid, out_data            | out_valid high, one cycle
//   config  | cfg_we, cfg_index, cfg_data    | cfg_we high
//
// On the accept edge the bucket row and its age row are read from the two memories
// into registers; in ST_EXEC all ways are compared, the result is registered and
// the changed rows are written back (entry row on an insert, age row on an insert
// or a hit). A new item is taken only after ST_EXEC is over. After reset a clearing
// pass writes every age/fill row with busy high. The receiver cannot stall.
module segment_summary_lru_cache_core #(
  parameter int unsigned BUCKETS   = sslc_pkg::BUCKETS_DEF,
  parameter int unsigned WAYS      = sslc_pkg::WAYS_DEF,
  parameter int unsigned CUR_SLOTS = sslc_pkg::CUR_SLOTS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  sslc_pkg::in_item_t                     in_data,
  output logic                                   out_valid,
  output sslc_pkg::out_item_t                    out_data,
  input  logic                                   cfg_we,
  input  logic [sslc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [sslc_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int unsigned ROWS   = 2 * BUCKETS;
  localparam int unsigned ROW_W  = $clog2(ROWS);
  localparam int unsigned BLOG   = $clog2(BUCKETS);
  localparam int unsigned WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned FILL_W = $clog2(WAYS + 1);
  localparam logic [sslc_pkg::KEY_W-1:0] BKT_MASK = sslc_pkg::KEY_W'(BUCKETS - 1);

  typedef logic [WAY_W-1:0] way_t;
  typedef struct packed {
    logic [FILL_W-1:0]  fill;
    way_t [WAYS-1:0]    order;
  } meta_t;
  typedef sslc_pkg::entry_t [WAYS-1:0] row_t;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_EXEC} state_t;

  state_t               state_r;
  logic [ROW_W-1:0]     clr_cnt_r;
  sslc_pkg::in_item_t   req_r;
  logic [ROW_W-1:0]     row_r;
  logic                 out_valid_r;
  sslc_pkg::out_item_t  out_data_r;

  logic [sslc_pkg::KEY_W-1:0]    node_seg_r [3];
  logic [sslc_pkg::KEY_W-1:0]    data_seg_r [3];
  logic [sslc_pkg::FOOTER_W-1:0] footer_r;

  row_t  ent_mem [ROWS];
  meta_t meta_mem [ROWS];
  row_t  ent_rd_r;
  meta_t meta_rd_r;

  logic                accept;
  logic [ROW_W-1:0]    in_row;
  meta_t               meta_rst;
  row_t                ent_wr;
  meta_t               meta_wr;
  meta_t               meta_wdata;
  logic [ROW_W-1:0]    meta_waddr;
  logic                ent_we;
  logic                meta_we;
  sslc_pkg::out_item_t res;

  logic [CUR_SLOTS-1:0] slot_hit;
  logic [CUR_SLOTS-1:0] slot_node;
  logic                 slot_any;
  logic [sslc_pkg::SLOT_W-1:0] slot_idx;
  logic                 slot_ok;
  logic                 hit;
  way_t                 hit_pos;
  way_t                 mn_pos;
  logic [FILL_W-1:0]    mn_fill;
  way_t [WAYS-1:0]      mn_order;
  logic                 full;
  way_t                 ins_way;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign in_row = ROW_W'((33'(in_data.table_req) << BLOG) | 33'(in_data.segment & BKT_MASK));

  always_comb begin
    meta_rst.fill = '0;
    for (int j = 0; j < WAYS; j++) begin
      meta_rst.order[j] = way_t'(j);
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        node_seg_r[i] <= sslc_pkg::CUR_SEG_RST;
        data_seg_r[i] <= sslc_pkg::CUR_SEG_RST;
      end
      footer_r <= sslc_pkg::FOOTER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        sslc_pkg::REG_NODE_A: node_seg_r[0] <= cfg_data;
        sslc_pkg::REG_NODE_B: node_seg_r[1] <= cfg_data;
        sslc_pkg::REG_NODE_C: node_seg_r[2] <= cfg_data;
        sslc_pkg::REG_DATA_A: data_seg_r[0] <= cfg_data;
        sslc_pkg::REG_DATA_B: data_seg_r[1] <= cfg_data;
        sslc_pkg::REG_DATA_C: data_seg_r[2] <= cfg_data;
        sslc_pkg::REG_FOOTER: footer_r <= cfg_data[sslc_pkg::FOOTER_W-1:0];
        default: ;
      endcase
    end
  end

  // Entry memory: one row per bucket, all ways side by side
  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[row_r] <= ent_wr;
    end
    if (accept) begin
      ent_rd_r <= ent_mem[in_row];
    end
  end

  // Fill and age order memory
  assign meta_waddr = (state_r == ST_CLEAR) ? clr_cnt_r : row_r;
  assign meta_wdata = (state_r == ST_CLEAR) ? meta_rst : meta_wr;

  always_ff @(posedge clk) begin
    if (meta_we || state_r == ST_CLEAR) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    if (accept) begin
      meta_rd_r <= meta_mem[in_row];
    end
  end

  // Current log slot compare
  always_comb begin
    for (int i = 0; i < CUR_SLOTS; i++) begin
      if (req_r.table_req == sslc_pkg::TBL_NODE) begin
        slot_hit[i]  = (node_seg_r[i] == req_r.segment);
        slot_node[i] = footer_r[i];
      end else begin
        slot_hit[i]  = (data_seg_r[i] == req_r.segment);
        slot_node[i] = footer_r[sslc_pkg::FOOTER_DATA_BASE + i];
      end
    end
    slot_any = 1'b0;
    slot_idx = '0;
    slot_ok  = 1'b0;
    for (int i = CUR_SLOTS - 1; i >= 0; i--) begin
      if (slot_hit[i]) begin
        slot_any = 1'b1;
        slot_idx = sslc_pkg::SLOT_W'(i);
        slot_ok  = (req_r.table_req == sslc_pkg::TBL_NODE) ? slot_node[i] : !slot_node[i];
      end
    end
  end

  // Way compare in age order; the oldest match wins
  always_comb begin
    hit     = 1'b0;
    hit_pos = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (FILL_W'(i) < meta_rd_r.fill &&
          ent_rd_r[meta_rd_r.order[i]].key == req_r.segment) begin
        hit     = 1'b1;
        hit_pos = way_t'(i);
      end
    end
  end

  assign full    = (meta_rd_r.fill >= FILL_W'(WAYS));
  assign ins_way = meta_rd_r.fill[WAY_W-1:0];

  // Move age position mn_pos to the newest end of the first mn_fill places
  always_comb begin
    if (req_r.action == sslc_pkg::ACT_INSERT) begin
      mn_pos  = '0;
      mn_fill = FILL_W'(WAYS);
    end else begin
      mn_pos  = hit_pos;
      mn_fill = meta_rd_r.fill;
    end
    for (int j = 0; j < WAYS; j++) begin
      if (way_t'(j) >= mn_pos && FILL_W'(j + 1) < mn_fill) begin
        mn_order[j] = meta_rd_r.order[(j + 1) % WAYS];
      end else if (way_t'(j) >= mn_pos && FILL_W'(j + 1) == mn_fill) begin
        mn_order[j] = meta_rd_r.order[mn_pos];
      end else begin
        mn_order[j] = meta_rd_r.order[j];
      end
    end
  end

  // Execute: build the result and the write-back rows
  always_comb begin
    res     = '0;
    ent_wr  = ent_rd_r;
    meta_wr = meta_rd_r;
    ent_we  = 1'b0;
    meta_we = 1'b0;
    if (state_r == ST_EXEC) begin
      if (req_r.action == sslc_pkg::ACT_INSERT) begin
        res.kind = sslc_pkg::KIND_INSERT;
        ent_we   = 1'b1;
        meta_we  = 1'b1;
        if (!full) begin
          ent_wr[ins_way].key    = req_r.segment;
          ent_wr[ins_way].handle = req_r.handle;
          meta_wr.order[ins_way] = ins_way;
          meta_wr.fill           = meta_rd_r.fill + 1'b1;
        end else begin
          res.evicted_valid  = 1'b1;
          res.evicted_handle = ent_rd_r[meta_rd_r.order[0]].handle;
          ent_wr[meta_rd_r.order[0]].key    = req_r.segment;
          ent_wr[meta_rd_r.order[0]].handle = req_r.handle;
          meta_wr.order = mn_order;
        end
      end else if (slot_any) begin
        res.kind         = slot_ok ? sslc_pkg::KIND_SLOT_OK : sslc_pkg::KIND_SLOT_BAD;
        res.current_slot = slot_idx;
      end else if (hit) begin
        res.kind         = sslc_pkg::KIND_HIT;
        res.found_handle = ent_rd_r[meta_rd_r.order[hit_pos]].handle;
        meta_wr.order    = mn_order;
        meta_we          = 1'b1;
      end else begin
        res.kind = sslc_pkg::KIND_MISS;
      end
    end
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == ROW_W'(ROWS - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            req_r   <= in_data;
            row_r   <= in_row;
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          out_valid_r <= 1'b1;
          out_data_r  <= res;
          state_r     <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== bench/tb_segment_summary_lru_cache_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the segment summary LRU cache core.
module tb_segment_summary_lru_cache_core;

  localparam int unsigned NB = sslc_pkg::BUCKETS_DEF;
  localparam int unsigned NW = sslc_pkg::WAYS_DEF;
  localparam int unsigned NSLOT = sslc_pkg::CUR_SLOTS_DEF;
  localparam int unsigned DRAIN_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam longint unsigned RUN_LIMIT_NS = 5_000_000;
  localparam int unsigned POOL_HI_W = sslc_pkg::KEY_W - 6;
  localparam int unsigned N_SEG_REGS = 6;
  localparam logic [sslc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [sslc_pkg::CFG_IDX_W-1:0] SEG_REGS [N_SEG_REGS] = '{
    sslc_pkg::REG_NODE_A, sslc_pkg::REG_NODE_B, sslc_pkg::REG_NODE_C,
    sslc_pkg::REG_DATA_A, sslc_pkg::REG_DATA_B, sslc_pkg::REG_DATA_C};

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            start;
  logic                            busy;
  sslc_pkg::in_item_t              in_data;
  logic                            out_valid;
  sslc_pkg::out_item_t             out_data;
  logic                            cfg_we;
  logic [sslc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [sslc_pkg::CFG_DATA_W-1:0] cfg_data;

  segment_summary_lru_cache_core dut (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow copy of the cache and its registers
  logic [sslc_pkg::KEY_W-1:0]    shadow_keys    [2][NB][NW];
  logic [sslc_pkg::HANDLE_W-1:0] shadow_handles [2][NB][NW];
  int unsigned                   shadow_fill    [2][NB];
  int unsigned                   shadow_age     [2][NB][NW];
  logic [sslc_pkg::KEY_W-1:0]    shadow_cur_seg [N_SEG_REGS];
  logic [sslc_pkg::FOOTER_W-1:0] shadow_footer;

  sslc_pkg::out_item_t pending_replies [$];
  int unsigned mismatch_count = 0;
  int unsigned burst_left = 0;
  bit          burst_quiet = 1'b0;

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      flag_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  task automatic clear_shadow();
    for (int t = 0; t < 2; t++)
      for (int b = 0; b < NB; b++) begin
        shadow_fill[t][b] = 0;
        for (int w = 0; w < NW; w++) shadow_age[t][b][w] = w;
      end
    foreach (shadow_cur_seg[r]) shadow_cur_seg[r] = sslc_pkg::CUR_SEG_RST;
    shadow_footer = sslc_pkg::FOOTER_RST;
  endtask

  // move age position pos to the newest end of the bucket
  task automatic promote_way(input int unsigned t, input int unsigned b,
                             input int unsigned fill, input int unsigned pos);
    int unsigned way;
    way = shadow_age[t][b][pos];
    for (int unsigned i = pos; i + 1 < fill; i++) shadow_age[t][b][i] = shadow_age[t][b][i + 1];
    shadow_age[t][b][fill - 1] = way;
  endtask

  task automatic resolve_summary(input sslc_pkg::in_item_t item,
                                 output sslc_pkg::out_item_t res);
    int unsigned t, b, fill, way, ridx;
    bit          done;
    bit          is_node;
    res = '0;
    t = (item.table_req == sslc_pkg::TBL_NODE) ? 1 : 0;
    b = item.segment % NB;
    fill = shadow_fill[t][b];
    done = 1'b0;
    if (item.action == sslc_pkg::ACT_INSERT) begin
      res.kind = sslc_pkg::KIND_INSERT;
      if (fill < NW) begin
        shadow_keys[t][b][fill] = item.segment;
        shadow_handles[t][b][fill] = item.handle;
        shadow_age[t][b][fill] = fill;
        shadow_fill[t][b] = fill + 1;
      end else begin
        way = shadow_age[t][b][0];
        res.evicted_valid = 1'b1;
        res.evicted_handle = shadow_handles[t][b][way];
        shadow_keys[t][b][way] = item.segment;
        shadow_handles[t][b][way] = item.handle;
        promote_way(t, b, NW, 0);
      end
    end else begin
      for (int unsigned s = 0; s < NSLOT && !done; s++) begin
        ridx = (t == 1) ? s : sslc_pkg::FOOTER_DATA_BASE + s;
        if (shadow_cur_seg[ridx] == item.segment) begin
          is_node = shadow_footer[ridx];
          res.kind = (is_node == (t == 1)) ? sslc_pkg::KIND_SLOT_OK : sslc_pkg::KIND_SLOT_BAD;
          res.current_slot = sslc_pkg::SLOT_W'(s);
          done = 1'b1;
        end
      end
      // oldest matching entry wins
      for (int unsigned pos = 0; pos < fill && !done; pos++) begin
        way = shadow_age[t][b][pos];
        if (shadow_keys[t][b][way] == item.segment) begin
          res.kind = sslc_pkg::KIND_HIT;
          res.found_handle = shadow_handles[t][b][way];
          promote_way(t, b, fill, pos);
          done = 1'b1;
        end
      end
    end
  endtask

  function automatic sslc_pkg::in_item_t make_item(input logic act, input logic tbl,
                                                   input logic [sslc_pkg::KEY_W-1:0] seg,
                                                   input logic [sslc_pkg::HANDLE_W-1:0] hnd);
    sslc_pkg::in_item_t it;
    it.action = act;
    it.table_req = tbl;
    it.segment = seg;
    it.handle = hnd;
    return it;
  endfunction

  function automatic int unsigned pick_gap();
    if (burst_left == 0) begin
      burst_left = $urandom_range(8, 40);
      burst_quiet = ($urandom_range(0, 2) == 0);
    end
    burst_left--;
    return burst_quiet ? 0 : $urandom_range(0, 19);
  endfunction

  // enter and leave at a falling edge; start stays high for a back-to-back beat
  task automatic send_item(input sslc_pkg::in_item_t item);
    int unsigned         gap;
    sslc_pkg::out_item_t want;
    gap = pick_gap();
    if (gap != 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    in_data = item;
    do @(posedge clk); while (busy);
    resolve_summary(item, want);
    pending_replies.push_back(want);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [sslc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sslc_pkg::CFG_DATA_W-1:0] value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(posedge clk);
    if (idx == sslc_pkg::REG_FOOTER) shadow_footer = value[sslc_pkg::FOOTER_W-1:0];
    else if (idx < sslc_pkg::REG_FOOTER) shadow_cur_seg[idx] = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic wait_idle();
    int unsigned waited;
    start = 1'b0;
    waited = 0;
    while (pending_replies.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_replies.size() != 0) begin
      flag_mismatch($sformatf("%0d results never arrived", pending_replies.size()));
      pending_replies.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  always @(posedge clk) begin : watch_results
    sslc_pkg::out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_replies.size() == 0) begin
        flag_mismatch($sformatf("result with nothing pending: 0x%0h", out_data));
      end else begin
        want = pending_replies.pop_front();
        check_field("kind", 32'(out_data.kind), 32'(want.kind));
        check_field("current_slot", 32'(out_data.current_slot), 32'(want.current_slot));
        check_field("found_handle", 32'(out_data.found_handle), 32'(want.found_handle));
        check_field("evicted_valid", 32'(out_data.evicted_valid), 32'(want.evicted_valid));
        check_field("evicted_handle", 32'(out_data.evicted_handle),
                    32'(want.evicted_handle));
      end
    end
  end

  task automatic test_reset_defaults();
    send_item(make_item(~sslc_pkg::ACT_INSERT, sslc_pkg::TBL_NODE, 32'hFFFF_FFFF, 16'h0000));
    send_item(make_item(~sslc_pkg::ACT_INSERT, ~sslc_pkg::TBL_NODE, 32'hFFFF_FFFF, 16'hFFFF));
    send_item(make_item(~sslc_pkg::ACT_INSERT, ~sslc_pkg::TBL_NODE, 32'h0000_0000, 16'hFFFF));
  endtask

  // fill one bucket, hit, evict, duplicate keys, insert on a current-slot key
  task automatic test_bucket_lru();
    send_item(make_item(sslc_pkg::ACT_INSERT, ~sslc_pkg::TBL_NODE, 32'h0000_0005, 16'h0000));
    send_item(make_item(sslc_pkg::ACT_INSERT, ~sslc_pkg::TBL_NODE, 32'h0000_0045, 16'hFFFF));
    send_item(make_item(sslc_pkg::ACT_INSERT, ~sslc_pkg::TBL_NODE, 32'h0000_0085, 16'h1111));
    send_item(make_item(sslc_pkg::ACT_INSERT, ~sslc_pkg::TBL_NODE, 32'h0000_00C5, 16'h2222));
    send_item(make_item(~sslc_pkg::ACT_INSERT, ~sslc_pkg::TBL_NODE, 32'h0000_0005, 16'h0000));
    send_item(make_item(sslc_pkg::ACT_INSERT, ~sslc_pkg::TBL_NODE, 32'h0000_0105, 16'h3333));
    send_item(make_item(sslc_pkg::ACT_INSERT, ~sslc_pkg::TBL_NODE, 32'h0000_0085, 16'h4444));
    send_item(make_item(~sslc_pkg::ACT_INSERT, ~sslc_pkg::TBL_NODE, 32'h0000_0085, 16'h0000));
    send_item(make_item(~sslc_pkg::ACT_INSERT, ~sslc_pkg::TBL_NODE, 32'h0000_0045, 16'h0000));
    send_item(make_item(sslc_pkg::ACT_INSERT, sslc_pkg::TBL_NODE, 32'hFFFF_FFFF, 16'h5555));
    send_item(make_item(~sslc_pkg::ACT_INSERT, sslc_pkg::TBL_NODE, 32'hFFFF_FFFF, 16'h0000));
  endtask

  task automatic test_current_slots();
    wait_idle();
    write_reg(sslc_pkg::REG_NODE_A, 32'h0000_1234);
    write_reg(sslc_pkg::REG_NODE_B, 32'h0000_1234);
    write_reg(sslc_pkg::REG_NODE_C, 32'h0000_0000);
    write_reg(sslc_pkg::REG_DATA_A, 32'hFFFF_FFFF);
    write_reg(sslc_pkg::REG_DATA_B, 32'h0000_0005);
    write_reg(sslc_pkg::REG_DATA_C, 32'hDEAD_BEEF);
    write_reg(sslc_pkg::REG_FOOTER, 32'hFFFF_FFEA);  // upper bits dropped
    write_reg(REG_UNUSED, 32'h0000_0000);  // no such register
    send_item(make_item(~sslc_pkg::ACT_INSERT, sslc_pkg::TBL_NODE, 32'h0000_1234, 16'h0000));
    send_item(make_item(~sslc_pkg::ACT_INSERT, sslc_pkg::TBL_NODE, 32'h0000_0000, 16'h0000));
    send_item(make_item(~sslc_pkg::ACT_INSERT, ~sslc_pkg::TBL_NODE, 32'h0000_0005, 16'h0000));
    send_item(make_item(~sslc_pkg::ACT_INSERT, ~sslc_pkg::TBL_NODE, 32'hDEAD_BEEF, 16'h0000));
    wait_idle();
    write_reg(sslc_pkg::REG_FOOTER, 32'h0000_003F);
    send_item(make_item(~sslc_pkg::ACT_INSERT, ~sslc_pkg::TBL_NODE, 32'hFFFF_FFFF, 16'h0000));
    send_item(make_item(~sslc_pkg::ACT_INSERT, sslc_pkg::TBL_NODE, 32'h0000_1234, 16'h0000));
    wait_idle();
    write_reg(sslc_pkg::REG_FOOTER, 32'h0000_0000);
    send_item(make_item(~sslc_pkg::ACT_INSERT, sslc_pkg::TBL_NODE, 32'h0000_0000, 16'h0000));
    send_item(make_item(~sslc_pkg::ACT_INSERT, ~sslc_pkg::TBL_NODE, 32'h0000_0005, 16'h0000));
  endtask

  // phases of traffic on a few crowded buckets, each under its own register setting
  task automatic test_random_traffic(input int unsigned n_items);
    localparam int unsigned PHASES = 8;
    logic [POOL_HI_W-1:0]            pool_hi  [3];
    logic [5:0]                      pool_bkt [3];
    logic [sslc_pkg::KEY_W-1:0]      seg;
    logic [sslc_pkg::CFG_DATA_W-1:0] value;
    logic                            act;
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      foreach (pool_hi[i]) begin
        pool_hi[i] = POOL_HI_W'($urandom);
        pool_bkt[i] = 6'($urandom);
      end
      if (ph == 2) begin
        pool_hi[0] = '0;
        pool_hi[1] = '1;
      end
      for (int unsigned r = 0; r < N_SEG_REGS; r++) begin
        case ($urandom_range(0, 3))
          0: value = $urandom;
          1: value = ($urandom_range(0, 1) == 0) ? 32'h0000_0000 : 32'hFFFF_FFFF;
          default: value = {pool_hi[$urandom_range(0, 2)], pool_bkt[$urandom_range(0, 2)]};
        endcase
        if (ph == 0) value = 32'h0000_0000;
        if (ph == 1) value = 32'hFFFF_FFFF;
        write_reg(SEG_REGS[r], value);
      end
      value = $urandom;
      if (ph == 0) value = 32'h0000_0000;
      if (ph == 1) value = 32'h0000_003F;
      write_reg(sslc_pkg::REG_FOOTER, value);
      if (ph == 3) write_reg(REG_UNUSED, $urandom);
      for (int unsigned n = 0; n < n_items / PHASES; n++) begin
        if ($urandom_range(0, 99) < 85) begin
          seg = {pool_hi[$urandom_range(0, 2)], pool_bkt[$urandom_range(0, 2)]};
          act = ($urandom_range(0, 99) < 45) ? sslc_pkg::ACT_INSERT : ~sslc_pkg::ACT_INSERT;
          if (act != sslc_pkg::ACT_INSERT && $urandom_range(0, 9) == 0)
            seg = shadow_cur_seg[$urandom_range(0, 5)];
        end else begin
          seg = $urandom;
          act = 1'($urandom_range(0, 1));
        end
        send_item(make_item(act, 1'($urandom_range(0, 1)), seg,
                            sslc_pkg::HANDLE_W'($urandom_range(0, 65535))));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    clear_shadow();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    // hold off through the clearing pass
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);

    test_reset_defaults();
    test_bucket_lru();
    test_current_slots();
    test_random_traffic(1900);
    wait_idle();

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("[%0t] timeout", $realtime);
    $display("Test completed with failures");
    $finish;
  end

endmodule
